// ===== src/shelf_atlas_packer_blitter_top_assert.svh =====
// Assertion macros for the shelf atlas packer blitter checker.
// Used by sapb_checker.sv; needs no other file.
`ifndef SHELF_ATLAS_PACKER_BLITTER_TOP_ASSERT_SVH
`define SHELF_ATLAS_PACKER_BLITTER_TOP_ASSERT_SVH

// Check a property outside reset.
`define SAPB_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define SAPB_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sapb_pkg.sv =====
// Shared types, constants and helpers of the shelf atlas packer blitter.
// Used by every RTL module of the block; depends on nothing.
package sapb_pkg;

	// Largest atlas the block supports
	localparam int MAX_ATLAS_WIDTH  = 512;
	localparam int MAX_ATLAS_HEIGHT = 256;

	// Field widths
	localparam int GW_W    = 10;
	localparam int GH_W    = 9;
	localparam int GRAY_W  = 8;
	localparam int SCOL_W  = 9;
	localparam int SROW_W  = 8;
	localparam int ADDR_W  = 17;
	localparam int AW_W    = 10;
	localparam int AH_W    = 9;
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 10;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_ATLAS_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_ATLAS_HEIGHT = 1'b1;

	// Reset values of the registers
	localparam logic [AW_W-1:0] ATLAS_WIDTH_RESET  = 10'd512;
	localparam logic [AH_W-1:0] ATLAS_HEIGHT_RESET = 9'd256;

	// Item modes and result kinds
	localparam logic MODE_BEGIN = 1'b0;
	localparam logic MODE_PIXEL = 1'b1;
	localparam logic KIND_SLOT  = 1'b0;
	localparam logic KIND_PIXEL = 1'b1;

	// Clamp limits expressed in register width
	localparam logic [AW_W-1:0] ATLAS_W_LIMIT =
		(MAX_ATLAS_WIDTH > 1023) ? 10'd1023 : AW_W'(MAX_ATLAS_WIDTH);
	localparam logic [AH_W-1:0] ATLAS_H_LIMIT =
		(MAX_ATLAS_HEIGHT > 511) ? 9'd511 : AH_W'(MAX_ATLAS_HEIGHT);

	// Placement of a begin transaction
	typedef struct packed {
		logic             empty;
		logic             no_space;
		logic             placed;
		logic [8:0]       column;
		logic [8:0]       row;
	} place_t;

	// Pixel write command
	typedef struct packed {
		logic              enable;
		logic [ADDR_W-1:0] address;
		logic [GRAY_W-1:0] data;
	} write_t;

	// Width in use: zero acts as one, capped at the maximum
	function automatic logic [AW_W-1:0] clamp_width(input logic [AW_W-1:0] v);
		logic [AW_W-1:0] r;
		if (v == '0)
			r = AW_W'(1);
		else if (v > ATLAS_W_LIMIT)
			r = ATLAS_W_LIMIT;
		else
			r = v;
		return r;
	endfunction

	// Height in use: zero acts as one, capped at the maximum
	function automatic logic [AH_W-1:0] clamp_height(input logic [AH_W-1:0] v);
		logic [AH_W-1:0] r;
		if (v == '0)
			r = AH_W'(1);
		else if (v > ATLAS_H_LIMIT)
			r = ATLAS_H_LIMIT;
		else
			r = v;
		return r;
	endfunction

endpackage

// ===== src/sapb_placer.sv =====
// Shelf placer: cursor and shelf state, places one glyph per begin transaction.
// Depends on sapb_pkg.
module sapb_placer
	import sapb_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            fire_begin,
	input  logic [GW_W-1:0] bitmap_width,
	input  logic [GH_W-1:0] bitmap_height,
	input  logic [AW_W-1:0] aw,
	input  logic [AH_W-1:0] ah,
	output place_t          place
);

	logic [9:0]  cursor_column_q;
	logic [9:0]  cursor_row_q;
	logic [8:0]  shelf_height_q;

	logic [10:0] col_sum;
	logic        wrap;
	logic [10:0] row_sum;
	logic [9:0]  wrap_row;
	logic [9:0]  col_eff;
	logic [9:0]  row_eff;
	logic [8:0]  shelf_eff;
	logic        empty;
	logic        refuse;
	logic [10:0] bottom;

	// Wrap to a new shelf, then check the fit
	always_comb begin
		col_sum   = {1'b0, cursor_column_q} + {1'b0, bitmap_width};
		wrap      = col_sum > {1'b0, aw};
		row_sum   = {1'b0, cursor_row_q} + 11'(shelf_height_q);
		wrap_row  = (row_sum > 11'd1023) ? 10'd1023 : row_sum[9:0];
		col_eff   = wrap ? 10'd0 : cursor_column_q;
		row_eff   = wrap ? wrap_row : cursor_row_q;
		shelf_eff = wrap ? 9'd0 : shelf_height_q;
		empty     = (bitmap_width == '0) || (bitmap_height == '0);
		bottom    = {1'b0, row_eff} + 11'(bitmap_height);
		refuse    = (bitmap_width > aw) || (bottom > 11'(ah));
		place.empty    = empty;
		place.no_space = !empty && refuse;
		place.placed   = !empty && !refuse;
		place.column   = col_eff[8:0];
		place.row      = row_eff[8:0];
	end

	// Advance the cursor; a wrap stays even when the glyph is refused
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_column_q <= '0;
			cursor_row_q    <= '0;
			shelf_height_q  <= '0;
		end else if (fire_begin && !empty) begin
			cursor_row_q <= row_eff;
			if (place.placed) begin
				cursor_column_q <= 10'(col_eff + bitmap_width);
				shelf_height_q  <= (bitmap_height > shelf_eff) ? bitmap_height : shelf_eff;
			end else begin
				cursor_column_q <= col_eff;
				shelf_height_q  <= shelf_eff;
			end
		end
	end

endmodule

// ===== src/sapb_blitter.sv =====
// Pixel blitter: walks the placed glyph row-major and forms atlas write commands.
// Depends on sapb_pkg.
module sapb_blitter
	import sapb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire_begin,
	input  logic              fire_pixel,
	input  place_t            place,
	input  logic [GW_W-1:0]   bitmap_width,
	input  logic [GH_W-1:0]   bitmap_height,
	input  logic [GRAY_W-1:0] pixel_gray,
	input  logic [AW_W-1:0]   aw,
	output write_t            wr
);

	logic             glyph_placed_q;
	logic [8:0]       placed_column_q;
	logic [8:0]       placed_row_q;
	logic [GW_W-1:0]  current_width_q;
	logic [GH_W-1:0]  current_height_q;
	logic [8:0]       pixel_column_q;
	logic [8:0]       pixel_row_q;

	logic [9:0]  col_abs;
	logic [9:0]  row_abs;
	logic [19:0] row_base;
	logic [19:0] addr_full;
	logic [9:0]  col_next;
	logic [9:0]  row_next;
	logic        col_wrap;
	logic        row_wrap;

	// Address is column plus row times the atlas width
	always_comb begin
		col_abs   = {1'b0, placed_column_q} + {1'b0, pixel_column_q};
		row_abs   = {1'b0, placed_row_q} + {1'b0, pixel_row_q};
		row_base  = row_abs * aw;
		addr_full = 20'(col_abs) + row_base;
		col_next  = {1'b0, pixel_column_q} + 10'd1;
		row_next  = {1'b0, pixel_row_q} + 10'd1;
		col_wrap  = col_next >= current_width_q;
		row_wrap  = row_next >= {1'b0, current_height_q};
		wr.enable  = glyph_placed_q;
		wr.address = glyph_placed_q ? addr_full[ADDR_W-1:0] : '0;
		wr.data    = glyph_placed_q ? pixel_gray : '0;
	end

	// Latch the new glyph, or step through its pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_placed_q   <= 1'b0;
			placed_column_q  <= '0;
			placed_row_q     <= '0;
			current_width_q  <= '0;
			current_height_q <= '0;
			pixel_column_q   <= '0;
			pixel_row_q      <= '0;
		end else if (fire_begin) begin
			glyph_placed_q   <= place.placed;
			placed_column_q  <= place.column;
			placed_row_q     <= place.row;
			current_width_q  <= bitmap_width;
			current_height_q <= bitmap_height;
			pixel_column_q   <= '0;
			pixel_row_q      <= '0;
		end else if (fire_pixel && glyph_placed_q) begin
			if (col_wrap) begin
				pixel_column_q <= '0;
				if (row_wrap) begin
					pixel_row_q    <= '0;
					glyph_placed_q <= 1'b0;
				end else begin
					pixel_row_q <= row_next[8:0];
				end
			end else begin
				pixel_column_q <= col_next[8:0];
			end
		end
	end

endmodule

// ===== src/shelf_atlas_packer_blitter_top.sv =====
// Top level of the shelf atlas packer blitter: input register, configuration
// registers, placer, blitter and result register. Depends on sapb_pkg,
// sapb_placer and sapb_blitter.
//
// Takes one transaction per cycle while the output is not stalled and gives
// one result per transaction, in order; the result passes the input register
// and then the result register, and is taken at an edge where the output is
// not stalled. A begin transaction (mode 0) places the glyph on the current
// shelf with compare-and-add logic; each pixel transaction (mode 1) costs one
// 10x10 multiply and one add for its atlas address in the same stage. The input
// register and the result register are separate, so a new transaction is taken
// while a finished result waits. Configuration writes are always ready and take
// effect on the next transaction; write them only while the block is idle.
module shelf_atlas_packer_blitter_top
	import sapb_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// Input channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   mode,
	input  logic [GW_W-1:0]        bitmap_width,
	input  logic [GH_W-1:0]        bitmap_height,
	input  logic [GRAY_W-1:0]      pixel_gray,
	// Result channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   kind,
	output logic [SCOL_W-1:0]      slot_column,
	output logic [SROW_W-1:0]      slot_row,
	output logic                   no_space,
	output logic                   empty_glyph,
	output logic                   write_enable,
	output logic [ADDR_W-1:0]      write_address,
	output logic [GRAY_W-1:0]      write_data,
	// Configuration channel
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	logic [AW_W-1:0]   atlas_width_q;
	logic [AH_W-1:0]   atlas_height_q;
	logic [AW_W-1:0]   aw;
	logic [AH_W-1:0]   ah;

	logic              valid_s1;
	logic              mode_s1;
	logic [GW_W-1:0]   bitmap_width_s1;
	logic [GH_W-1:0]   bitmap_height_s1;
	logic [GRAY_W-1:0] pixel_gray_s1;

	logic              advance;
	logic              fire;
	logic              fire_begin;
	logic              fire_pixel;
	place_t            place;
	write_t            wr;

	logic              out_valid_q;
	logic              kind_q;
	logic [SCOL_W-1:0] slot_column_q;
	logic [SROW_W-1:0] slot_row_q;
	logic              no_space_q;
	logic              empty_glyph_q;
	logic              write_enable_q;
	logic [ADDR_W-1:0] write_address_q;
	logic [GRAY_W-1:0] write_data_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_width_q  <= ATLAS_WIDTH_RESET;
			atlas_height_q <= ATLAS_HEIGHT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ATLAS_WIDTH:  atlas_width_q  <= cfg_data;
				REG_ATLAS_HEIGHT: atlas_height_q <= cfg_data[AH_W-1:0];
				default: ;
			endcase
		end
	end

	assign aw = clamp_width(atlas_width_q);
	assign ah = clamp_height(atlas_height_q);

	// Handshake: stage 1 moves on when the result register is empty or its result is taken
	assign advance    = !out_valid_q || !out_stall;
	assign fire       = valid_s1 && advance;
	assign fire_begin = fire && (mode_s1 == MODE_BEGIN);
	assign fire_pixel = fire && (mode_s1 == MODE_PIXEL);
	assign in_stall   = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_s1          <= mode;
			bitmap_width_s1  <= bitmap_width;
			bitmap_height_s1 <= bitmap_height;
			pixel_gray_s1    <= pixel_gray;
		end
	end

	sapb_placer u_placer (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire_begin    (fire_begin),
		.bitmap_width  (bitmap_width_s1),
		.bitmap_height (bitmap_height_s1),
		.aw            (aw),
		.ah            (ah),
		.place         (place)
	);

	sapb_blitter u_blitter (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire_begin    (fire_begin),
		.fire_pixel    (fire_pixel),
		.place         (place),
		.bitmap_width  (bitmap_width_s1),
		.bitmap_height (bitmap_height_s1),
		.pixel_gray    (pixel_gray_s1),
		.aw            (aw),
		.wr            (wr)
	);

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (fire) begin
			if (mode_s1 == MODE_BEGIN) begin
				kind_q          <= KIND_SLOT;
				slot_column_q   <= place.placed ? place.column : '0;
				slot_row_q      <= place.placed ? place.row[SROW_W-1:0] : '0;
				no_space_q      <= place.no_space;
				empty_glyph_q   <= place.empty;
				write_enable_q  <= 1'b0;
				write_address_q <= '0;
				write_data_q    <= '0;
			end else begin
				kind_q          <= KIND_PIXEL;
				slot_column_q   <= '0;
				slot_row_q      <= '0;
				no_space_q      <= 1'b0;
				empty_glyph_q   <= 1'b0;
				write_enable_q  <= wr.enable;
				write_address_q <= wr.address;
				write_data_q    <= wr.data;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign slot_column   = slot_column_q;
	assign slot_row      = slot_row_q;
	assign no_space      = no_space_q;
	assign empty_glyph   = empty_glyph_q;
	assign write_enable  = write_enable_q;
	assign write_address = write_address_q;
	assign write_data    = write_data_q;

endmodule

// ===== src/sapb_checker.sv =====
// Port-level checker for the shelf atlas packer blitter, bound to the top level.
// Depends on sapb_pkg and shelf_atlas_packer_blitter_top_assert.svh.
`include "shelf_atlas_packer_blitter_top_assert.svh"

module sapb_checker
	import sapb_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic              kind,
	input logic [SCOL_W-1:0] slot_column,
	input logic [SROW_W-1:0] slot_row,
	input logic              no_space,
	input logic              empty_glyph,
	input logic              write_enable,
	input logic [ADDR_W-1:0] write_address,
	input logic [GRAY_W-1:0] write_data
);

	// A result is never valid right after an edge that sees reset asserted
	`SAPB_ASSERT_ALWAYS(a_no_result_in_reset, clk,
		!arst_n |=> !out_valid,
		"result valid in reset")

	// A stalled result transaction stays and holds its address
	`SAPB_ASSERT(a_stall_hold, clk, arst_n,
		out_valid && out_stall |=> out_valid && $stable(write_address),
		"stalled result changed")

	// Slot reports never write, and pixel results carry no slot flags
	`SAPB_ASSERT(a_kind_fields, clk, arst_n,
		out_valid |-> (kind == KIND_SLOT && !write_enable) ||
		(kind == KIND_PIXEL && !no_space && !empty_glyph &&
		slot_column == '0 && slot_row == '0),
		"field outside its kind")

	// Suppressed writes carry zero address and data
	`SAPB_ASSERT(a_quiet_write, clk, arst_n,
		out_valid && !write_enable |-> write_address == '0 && write_data == '0,
		"suppressed write not zero")

	// A refused or empty glyph reports slot zero, never both flags
	`SAPB_ASSERT(a_refused_slot, clk, arst_n,
		out_valid && (no_space || empty_glyph) |->
		slot_column == '0 && slot_row == '0 && !(no_space && empty_glyph),
		"refused glyph slot not zero")

endmodule

bind shelf_atlas_packer_blitter_top sapb_checker u_sapb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.kind          (kind),
	.slot_column   (slot_column),
	.slot_row      (slot_row),
	.no_space      (no_space),
	.empty_glyph   (empty_glyph),
	.write_enable  (write_enable),
	.write_address (write_address),
	.write_data    (write_data)
);
